FILE: src/umf_pkg.sv
// umf_pkg: shared constants, register indexes and state type of the uart message framer
// no dependencies; imported by uart_message_framer_core, umf_checker and tb
package umf_pkg;

	// message buffer geometry
	localparam int MSG_DEPTH = 64;
	localparam int ADDR_W    = $clog2(MSG_DEPTH);
	localparam int CNT_W     = $clog2(MSG_DEPTH + 1);

	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int IDLE_W = 16;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_BRIDGE_EN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_END_BY_TERM = 2'd1;
	localparam logic [IDX_W-1:0] REG_TERM_BYTE  = 2'd2;
	localparam logic [IDX_W-1:0] REG_IDLE_TICKS = 2'd3;

	// input word kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// read-out sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT
	} umf_state_t;

endpackage

FILE: src/umf_ram.sv
// umf_ram: generic single-write, single-read memory with registered read data
// no dependencies
module umf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/uart_message_framer_core.sv
// uart_message_framer_core: assembles received uart bytes into messages in a buffer ram
// depends on umf_pkg and umf_ram
//
// Usage
// - input channel s_*: one word per received byte (tuser = 0, byte in tdata) or per
//   timer tick (tuser = 1). A word is taken whenever the framer is not reading out a
//   message and the output register is free or being emptied.
// - output channel m_*: one word per message byte, tlast on the final one, with the
//   message length and overflow flag; a bridged byte is a single word with tuser = 1.
// - config port: cfg_we writes cfg_data into register cfg_index (bridge enable,
//   end-by-terminator, terminator byte, idle ticks). The user must write only while
//   the framer is idle; the block does not enforce it.
// - timing: a bridged byte or an empty message appears the cycle after the word is
//   taken. A closed message is read out byte by byte, a registered ram read (ST_READ)
//   then an output load (ST_WAIT) once m_* is free; no input word is taken meanwhile.
// - reset: registers return to their defaults, byte count, idle counter and overflow
//   flag clear; buffer contents are undefined and are never read before written.
// - stall: a word held on m_* blocks read-out and the input; nothing is dropped.
module uart_message_framer_core
	import umf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// input channel
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
	input  logic              s_tuser,   // [0] mode
	// output channel
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [7:0] data_byte, [14:8] msg_length, [15] overflowed
	output logic              m_tlast,
	output logic              m_tuser,   // [0] is_bridged
	// configuration
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// configuration registers
	logic              bridge_en_q;
	logic              end_by_term_q;
	logic [BYTE_W-1:0] term_byte_q;
	logic [IDLE_W-1:0] idle_ticks_q;

	// framing state
	logic [CNT_W-1:0]  byte_cnt_q;
	logic [IDLE_W-1:0] idle_cnt_q;
	logic              ovf_q;

	// read-out state
	umf_state_t        state_q, state_d;
	logic [CNT_W-1:0]  msg_len_q;
	logic              msg_ovf_q;
	logic [ADDR_W-1:0] rd_idx_q;

	// output register
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_bridged_q;
	logic              out_last_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_ovf_q;

	// ram
	logic              ram_we;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	// decoded item
	logic              out_free;
	logic              accept;
	logic              is_tick;
	logic              buf_full;
	logic              do_store;
	logic              do_emit;
	logic              emit_empty;
	logic              emit_full;
	logic              do_bridge;
	logic              last_beat;
	logic              load_beat;

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_tick  = (s_tuser == MODE_TICK);
	assign buf_full = (byte_cnt_q == CNT_W'(MSG_DEPTH));

	// item decode
	always_comb begin
		do_bridge = 1'b0;
		do_store  = 1'b0;
		do_emit   = 1'b0;
		if (bridge_en_q) begin
			do_bridge = !is_tick;
		end else if (is_tick) begin
			do_emit = !end_by_term_q && (byte_cnt_q != '0) && (idle_cnt_q == '0);
		end else if (end_by_term_q && (s_tdata == term_byte_q)) begin
			do_emit = 1'b1;
		end else begin
			do_store = 1'b1;
		end
	end

	assign emit_empty = accept && do_emit && (byte_cnt_q == '0);
	assign emit_full  = accept && do_emit && (byte_cnt_q != '0);
	assign ram_we     = accept && do_store && !buf_full;
	assign last_beat  = ((CNT_W'(rd_idx_q) + CNT_W'(1)) == msg_len_q);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_en_q   <= 1'b0;
			end_by_term_q <= 1'b1;
			term_byte_q   <= BYTE_W'(10);
			idle_ticks_q  <= IDLE_W'(100);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIDGE_EN:   bridge_en_q   <= cfg_data[0];
				REG_END_BY_TERM: end_by_term_q <= cfg_data[0];
				REG_TERM_BYTE:   term_byte_q   <= cfg_data[BYTE_W-1:0];
				REG_IDLE_TICKS:  idle_ticks_q  <= cfg_data[IDLE_W-1:0];
				default: ;
			endcase
		end
	end

	// byte count, idle counter and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			idle_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (accept && !bridge_en_q) begin
			if (do_emit) begin
				byte_cnt_q <= '0;
				ovf_q      <= 1'b0;
			end else if (is_tick) begin
				if (!end_by_term_q && (byte_cnt_q != '0)) begin
					idle_cnt_q <= idle_cnt_q - IDLE_W'(1);
				end
			end else begin
				if (buf_full) begin
					ovf_q <= 1'b1;
				end else begin
					byte_cnt_q <= byte_cnt_q + CNT_W'(1);
				end
				if (!end_by_term_q) begin
					idle_cnt_q <= idle_ticks_q;
				end
			end
		end
	end

	// message buffer
	umf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MSG_DEPTH)
	) u_msg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (byte_cnt_q[ADDR_W-1:0]),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// read-out state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// read-out next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (emit_full) state_d = ST_READ;
			ST_READ: state_d = ST_WAIT;
			ST_WAIT: if (out_free) state_d = last_beat ? ST_IDLE : ST_READ;
			default: state_d = ST_IDLE;
		endcase
	end

	// read-out controls
	always_comb begin
		s_tready  = 1'b0;
		ram_re    = 1'b0;
		load_beat = 1'b0;
		case (state_q)
			ST_IDLE: s_tready  = out_free;
			ST_READ: ram_re    = 1'b1;
			ST_WAIT: load_beat = out_free;
			default: ;
		endcase
	end

	// message latch and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q <= '0;
			msg_ovf_q <= 1'b0;
			rd_idx_q  <= '0;
		end else if (emit_full) begin
			msg_len_q <= byte_cnt_q;
			msg_ovf_q <= ovf_q;
			rd_idx_q  <= '0;
		end else if (load_beat) begin
			rd_idx_q <= rd_idx_q + ADDR_W'(1);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && (do_bridge || emit_empty)) || load_beat) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_beat) begin
			out_data_q    <= ram_rdata;
			out_bridged_q <= 1'b0;
			out_last_q    <= last_beat;
			out_len_q     <= LEN_W'(msg_len_q);
			out_ovf_q     <= msg_ovf_q;
		end else if (accept && do_bridge) begin
			out_data_q    <= s_tdata;
			out_bridged_q <= 1'b1;
			out_last_q    <= 1'b1;
			out_len_q     <= LEN_W'(1);
			out_ovf_q     <= 1'b0;
		end else if (emit_empty) begin
			out_data_q    <= '0;
			out_bridged_q <= 1'b0;
			out_last_q    <= 1'b1;
			out_len_q     <= '0;
			out_ovf_q     <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ovf_q, out_len_q, out_data_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bridged_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= CNT_W'(MSG_DEPTH))
		else $error("byte count beyond buffer depth");

	a_cnt_clear_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (byte_cnt_q == '0))
		else $error("byte count not cleared during read-out");

	a_idx_in_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (CNT_W'(rd_idx_q) < msg_len_q))
		else $error("read index past message end");

	a_read_then_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_WAIT))
		else $error("ram read not followed by data wait");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !ram_we)
		else $error("buffer written during read-out");

endmodule

FILE: tb/umf_checker.sv
`timescale 1ns / 100ps
// umf_checker: watches the framer's input, output and register write ports and
// predicts every output word; depends on umf_pkg only
module umf_checker
	import umf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,    // [7:0] rx_byte
	input  logic              s_tuser,    // [0] mode
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,    // [7:0] data_byte, [14:8] msg_length, [15] overflowed
	input  logic              m_tlast,
	input  logic              m_tuser,    // [0] is_bridged
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output int                fail_count,
	output int                words_due,
	output int                words_in,
	output int                words_out,
	output int                msgs_done,
	output int                msgs_overflowed,
	output int                bytes_bridged
);

	// one output word as the framer should give it
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [LEN_W-1:0]  len;
		logic              ovf;
		logic              last;
		logic              bridged;
	} frame_word_t;

	// shadow of the configuration registers
	logic              bridge_en;
	logic              term_en;
	logic [BYTE_W-1:0] term_byte;
	logic [IDLE_W-1:0] idle_reload;

	// shadow of the framing state
	logic [BYTE_W-1:0] msg_buf [MSG_DEPTH];
	logic [CNT_W-1:0]  fill;
	logic [IDLE_W-1:0] idle_left;
	logic              dropped;

	frame_word_t due_words [$];

	initial begin
		fail_count      = 0;
		words_due       = 0;
		words_in        = 0;
		words_out       = 0;
		msgs_done       = 0;
		msgs_overflowed = 0;
		bytes_bridged   = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= 20)
			$display("mismatch at %0t ns: %s is %0d, should be %0d", $time, what, got, want);
	endtask

	// hand out the buffered message and start a fresh one
	task automatic close_message();
		int i;
		msgs_done++;
		if (dropped)
			msgs_overflowed++;
		if (fill == 0) begin
			due_words.push_back(frame_word_t'{data: '0, len: '0, ovf: dropped, last: 1'b1,
				bridged: 1'b0});
		end else begin
			for (i = 0; i < fill; i++)
				due_words.push_back(frame_word_t'{data: msg_buf[ADDR_W'(i)], len: LEN_W'(fill),
					ovf: dropped, last: (i == fill - 1), bridged: 1'b0});
		end
		fill    = '0;
		dropped = 1'b0;
	endtask

	// store a byte, or flag it as dropped once the buffer is full
	task automatic file_byte(input logic [BYTE_W-1:0] b);
		if (fill < MSG_DEPTH) begin
			msg_buf[fill[ADDR_W-1:0]] = b;
			fill = fill + 1'b1;
		end else begin
			dropped = 1'b1;
		end
	endtask

	// effect of one accepted input word
	task automatic absorb_input(input logic tick, input logic [BYTE_W-1:0] b);
		if (bridge_en) begin
			if (!tick) begin
				due_words.push_back(frame_word_t'{data: b, len: LEN_W'(1), ovf: 1'b0,
					last: 1'b1, bridged: 1'b1});
				bytes_bridged++;
			end
		end else if (tick) begin
			if (!term_en && fill != 0) begin
				if (idle_left == 0)
					close_message();
				else
					idle_left = idle_left - 1'b1;
			end
		end else if (term_en) begin
			if (b == term_byte)
				close_message();
			else
				file_byte(b);
		end else begin
			file_byte(b);
			idle_left = idle_reload;
		end
	endtask

	// compare one output word with the oldest one due
	task automatic compare_word();
		frame_word_t want;
		words_out++;
		if (due_words.size() == 0) begin
			report_mismatch("word with nothing due, tdata", m_tdata, 0);
		end else begin
			want = due_words.pop_front();
			if (m_tdata[7:0] != want.data)
				report_mismatch("data_byte", m_tdata[7:0], want.data);
			if (m_tdata[14:8] != want.len)
				report_mismatch("msg_length", m_tdata[14:8], want.len);
			if (m_tdata[15] != want.ovf)
				report_mismatch("overflowed", m_tdata[15], want.ovf);
			if (m_tlast != want.last)
				report_mismatch("last", m_tlast, want.last);
			if (m_tuser != want.bridged)
				report_mismatch("is_bridged", m_tuser, want.bridged);
		end
	endtask

	// outputs first, so a word taken at this edge never meets its own prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bridge_en   = 1'b0;
			term_en     = 1'b1;
			term_byte   = 8'd10;
			idle_reload = 16'd100;
			fill        = '0;
			idle_left   = '0;
			dropped     = 1'b0;
			due_words.delete();
		end else begin
			if (m_tvalid && m_tready)
				compare_word();
			if (cfg_we) begin
				case (cfg_index)
					REG_BRIDGE_EN:   bridge_en   = cfg_data[0];
					REG_END_BY_TERM: term_en     = cfg_data[0];
					REG_TERM_BYTE:   term_byte   = cfg_data[BYTE_W-1:0];
					REG_IDLE_TICKS:  idle_reload = cfg_data[IDLE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				words_in++;
				absorb_input(s_tuser == MODE_TICK, s_tdata);
			end
		end
		words_due = due_words.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: stimulus, receiver stalls, watchdog and verdict for uart_message_framer_core
// depends on umf_pkg, the framer core and umf_checker
module tb
	import umf_pkg::*;
();

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 130;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata   = '0;
	logic              s_tuser   = MODE_BYTE;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [15:0]       m_tdata;
	logic              m_tlast;
	logic              m_tuser;
	logic              cfg_we    = 1'b0;
	logic [IDX_W-1:0]  cfg_index = REG_BRIDGE_EN;
	logic [CFG_W-1:0]  cfg_data  = '0;

	int fail_count, words_due, words_in, words_out, msgs_done, msgs_overflowed, bytes_bridged;

	// current register values, so stimulus knows the rules in force
	logic              cur_bridge  = 1'b0;
	logic              cur_term_en = 1'b1;
	logic [BYTE_W-1:0] cur_term    = 8'd10;
	logic [IDLE_W-1:0] cur_idle    = 16'd100;

	int  counted_items = 0;
	int  settings_made = 0;
	int  calm_left     = 0;
	int  rx_calm       = 0;
	int  hold_off_len  = 0;
	bit  no_gaps       = 1'b0;

	always #2 clk = ~clk;

	uart_message_framer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	umf_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.words_due      (words_due),
		.words_in       (words_in),
		.words_out      (words_out),
		.msgs_done      (msgs_done),
		.msgs_overflowed(msgs_overflowed),
		.bytes_bridged  (bytes_bridged)
	);

	// offer one input word after a random gap and wait until it is taken
	task automatic send_word(input logic md, input logic [BYTE_W-1:0] b);
		int gap;
		if (no_gaps || calm_left > 0) begin
			gap = 0;
			if (calm_left > 0)
				calm_left--;
		end else begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 39) == 0)
				calm_left = $urandom_range(8, 30);
		end
		if (!(md == MODE_TICK && (cur_bridge || cur_term_en)))
			counted_items++;
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_word(MODE_TICK, BYTE_W'($urandom_range(0, 255)));
	endtask

	// wait for every due word and for the framer to settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	// write all four registers while the framer is idle
	task automatic set_config(input logic nb, input logic nt, input logic [BYTE_W-1:0] term,
			input logic [IDLE_W-1:0] idle);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BRIDGE_EN;
		cfg_data  <= CFG_W'(nb);
		@(posedge clk);
		cfg_index <= REG_END_BY_TERM;
		cfg_data  <= CFG_W'(nt);
		@(posedge clk);
		cfg_index <= REG_TERM_BYTE;
		cfg_data  <= CFG_W'(term);
		@(posedge clk);
		cfg_index <= REG_IDLE_TICKS;
		cfg_data  <= CFG_W'(idle);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_bridge  = nb;
		cur_term_en = nt;
		cur_term    = term;
		cur_idle    = idle;
		settings_made++;
	endtask

	// one random run of words under the rules in force
	task automatic run_sequence();
		int len, i, k;
		logic [BYTE_W-1:0] b;
		if (cur_bridge) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 5) == 0)
					send_word(MODE_TICK, BYTE_W'($urandom_range(0, 255)));
				else
					send_word(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
			end
		end else begin
			k = $urandom_range(0, 11);
			len = (k == 0) ? $urandom_range(60, 70) : (k == 1) ? 0 : $urandom_range(1, 8);
			for (i = 0; i < len; i++) begin
				b = BYTE_W'($urandom_range(0, 255));
				if (cur_term_en && b == cur_term)
					b = ~b;
				send_word(MODE_BYTE, b);
				if (cur_term_en) begin
					if ($urandom_range(0, 7) == 0)
						send_ticks(1);
				end else if ($urandom_range(0, 2) == 0) begin
					// stays open: at most idle_ticks ticks between bytes
					send_ticks($urandom_range(0, cur_idle));
				end
			end
			// close most runs properly; leave the rest open or spoil them
			if ($urandom_range(0, 7) != 0) begin
				if (cur_term_en)
					send_word(MODE_BYTE, cur_term);
				else
					send_ticks(int'(cur_idle) + 1);
			end else if ($urandom_range(0, 1) == 1) begin
				send_word(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// receiver: random stall per word, calm stretches, and one long hold-off on request
	initial begin : receiver
		int gap, n;
		forever begin
			if (hold_off_len > 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				m_tready <= 1'b0;
				repeat (n)
					@(posedge clk);
			end
			if (rx_calm > 0) begin
				gap = 0;
				rx_calm--;
			end else begin
				gap = $urandom_range(0, 17);
				if ($urandom_range(0, 39) == 0)
					rx_calm = $urandom_range(8, 30);
			end
			repeat (gap) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// watchdog on cycles without any handshake
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
		$display("tb NOT OK");
		$finish;
	end

	// main stimulus
	initial begin : stimulus
		int r, start;
		logic nb, nt;
		logic [BYTE_W-1:0] term;
		logic [IDLE_W-1:0] idle;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: terminator 10, then an empty terminated message, ignored tick
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		send_word(MODE_BYTE, 8'h5A);
		send_word(MODE_BYTE, 8'd10);
		send_word(MODE_BYTE, 8'd10);
		send_word(MODE_TICK, 8'hFF);

		// bridge mode: extremes, the terminator value, a tick that does nothing
		set_config(1'b1, 1'b1, 8'd10, 16'd100);
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		send_word(MODE_BYTE, 8'd10);
		send_word(MODE_TICK, 8'h00);

		// timeout mode with the shortest timeout; tick on empty buffer does nothing
		set_config(1'b0, 1'b0, 8'hFF, 16'd0);
		send_word(MODE_TICK, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		send_word(MODE_TICK, 8'h00);
		send_word(MODE_BYTE, 8'h01);
		send_word(MODE_BYTE, 8'h80);
		send_word(MODE_TICK, 8'hFF);

		// terminator zero: empty message, then a one-byte message
		set_config(1'b0, 1'b1, 8'h00, 16'd3);
		send_word(MODE_BYTE, 8'h00);
		send_word(MODE_BYTE, 8'hFF);
		send_word(MODE_BYTE, 8'h00);

		// mode change mid-message: stored byte closes under the timeout rule
		send_word(MODE_BYTE, 8'h33);
		set_config(1'b0, 1'b0, 8'h00, 16'd1);
		send_ticks(2);

		// back-pressure: receiver holds off while bridged bytes keep coming
		set_config(1'b1, 1'b0, 8'd10, 16'd5);
		no_gaps = 1'b1;
		hold_off_len = 300;
		repeat (20)
			send_word(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
		// an overflowing terminated message read out under the same stall
		set_config(1'b0, 1'b1, 8'd13, 16'd5);
		hold_off_len = 300;
		repeat (66)
			send_word(MODE_BYTE, 8'h40 | 8'($urandom_range(0, 7)));
		send_word(MODE_BYTE, 8'd13);
		// overflow in timeout mode: dropped bytes still reload the counter
		set_config(1'b0, 1'b0, 8'd13, 16'd2);
		repeat (65)
			send_word(MODE_BYTE, BYTE_W'($urandom_range(0, 255)));
		send_ticks(3);
		no_gaps = 1'b0;

		// random phases with random register settings
		start = counted_items;
		while (counted_items - start < RANDOM_ITEMS) begin
			r  = $urandom_range(0, 9);
			nb = (r < 2);
			nt = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0:       term = 8'h00;
				1:       term = 8'hFF;
				2:       term = 8'd10;
				default: term = BYTE_W'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 7) == 0)
				idle = IDLE_W'($urandom_range(0, 40));
			else
				idle = IDLE_W'($urandom_range(0, 6));
			set_config(nb, nt, term, idle);
			repeat ($urandom_range(3, 8))
				run_sequence();
		end

		// largest timeout: the full sixteen-bit reload keeps the message open
		set_config(1'b0, 1'b0, 8'd10, 16'hFFFF);
		no_gaps = 1'b1;
		send_word(MODE_BYTE, 8'h11);
		send_ticks(20);
		send_word(MODE_BYTE, 8'h22);
		send_ticks(20);
		no_gaps = 1'b0;
		// the open message then closes under the terminator rule
		set_config(1'b0, 1'b1, 8'd10, 16'hFFFF);
		send_word(MODE_BYTE, 8'd10);

		// wind down
		drain();
		repeat (20)
			@(posedge clk);

		$display("covered %0d input words and %0d output words over %0d register settings",
			words_in, words_out, settings_made);
		$display("%0d messages closed (%0d with dropped bytes), %0d bytes bridged",
			msgs_done, msgs_overflowed, bytes_bridged);
		if (fail_count == 0 && words_due == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
